### design/ssme_pkg.sv
// Shared constants, codes and handshake structs of the sorted set merge engine.
`default_nettype none

package ssme_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int DATA_W     = 32;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_RUN    = 2'd2;

    localparam logic [1:0] MODE_MERGE = 2'd0;
    localparam logic [1:0] MODE_UNION = 2'd1;
    localparam logic [1:0] MODE_INTER = 2'd2;
    localparam logic [1:0] MODE_DIFF  = 2'd3;

    localparam logic [0:0] REG_SET_MODE = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_FIN
    } ssme_state_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic clr_ptr;
        logic adv_i;
        logic adv_j;
        logic emit;
        logic emit_sel_b;
        logic fin;
    } ssme_cmd_t;

    typedef struct packed {
        logic a_avail;
        logic b_avail;
        logic a_lt_b;
        logic b_lt_a;
        logic pend_valid;
        logic out_busy;
    } ssme_stat_t;

endpackage

`default_nettype wire

### design/sorted_set_merge_engine_top.sv
// Top level of the sorted set merge engine: register port, controller and datapath.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// apb       in/out     psel, penable, pready     paddr, pwrite, pwdata, prdata (set_mode)
// in        in         in_valid / in_ready       op, element
// out       out        out_valid / out_ready     value, is_last, is_empty, overflow
//
// A load transfer (op append to A or B) is taken while the engine is idle, and in_ready stays high.
// A run walks both lists with two pointers, each step passing a registered read state and a compare
// state; in_ready stays low until the final result is pushed, and each step advances a pointer.
// Reset empties both lists and clears the mode and the overflow flag; the memories keep their data.
// A stalled output holds the walk at its compare step; one result waits in a hold stage so that
// is_last can be set, and the final result may wait in the output register as the next transfer lands.

module sorted_set_merge_engine_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [ssme_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire logic [ssme_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [ssme_pkg::APB_DATA_W-1:0]            prdata,
    output logic                                       pready,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [1:0]                            op,
    input  wire logic signed [ssme_pkg::DATA_W-1:0]    element,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [ssme_pkg::DATA_W-1:0]         value,
    output logic                                       is_last,
    output logic                                       is_empty,
    output logic                                       overflow
);

    ssme_pkg::ssme_cmd_t  cmd;
    ssme_pkg::ssme_stat_t status;

    logic [1:0] set_mode_reg, set_mode_next;
    logic       reg_sel;
    logic       cfg_write;

    // Register index is the word address; only index zero holds a register.
    assign reg_sel   = (paddr[2] == ssme_pkg::REG_SET_MODE);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        set_mode_next = set_mode_reg;
        if (cfg_write && reg_sel)
        begin
            set_mode_next = pwdata[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_mode_reg <= ssme_pkg::MODE_MERGE;
        end
        else
        begin
            set_mode_reg <= set_mode_next;
        end
    end

    // Reads return the mode register, and zero at addresses with no register.
    assign prdata = reg_sel ? {{(ssme_pkg::APB_DATA_W-2){1'b0}}, set_mode_reg} : '0;

    ssme_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .mode     (set_mode_reg),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    ssme_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .element   (element),
        .out_ready (out_ready),
        .status    (status),
        .out_valid (out_valid),
        .value     (value),
        .is_last   (is_last),
        .is_empty  (is_empty),
        .overflow  (overflow)
    );

endmodule

`default_nettype wire

### design/ssme_datapath.sv
// Datapath: list memories, counts, walk pointers, hold stage and output register.
`default_nettype none

module ssme_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ssme_pkg::ssme_cmd_t               cmd,
    input  wire logic signed [ssme_pkg::DATA_W-1:0] element,
    input  wire logic                              out_ready,
    output ssme_pkg::ssme_stat_t                   status,
    output logic                                   out_valid,
    output logic signed [ssme_pkg::DATA_W-1:0]     value,
    output logic                                   is_last,
    output logic                                   is_empty,
    output logic                                   overflow
);

    logic [ssme_pkg::DATA_W-1:0] mem_a [ssme_pkg::LIST_DEPTH];
    logic [ssme_pkg::DATA_W-1:0] mem_b [ssme_pkg::LIST_DEPTH];

    logic [ssme_pkg::DATA_W-1:0] rd_a_reg;
    logic [ssme_pkg::DATA_W-1:0] rd_b_reg;

    logic [ssme_pkg::CNT_W-1:0] count_a_reg, count_a_next;
    logic [ssme_pkg::CNT_W-1:0] count_b_reg, count_b_next;
    logic [ssme_pkg::CNT_W-1:0] ptr_i_reg, ptr_i_next;
    logic [ssme_pkg::CNT_W-1:0] ptr_j_reg, ptr_j_next;
    logic                       dropped_reg, dropped_next;

    logic [ssme_pkg::DATA_W-1:0] pend_value_reg, pend_value_next;
    logic                        pend_valid_reg, pend_valid_next;

    logic                        out_valid_reg, out_valid_next;
    logic [ssme_pkg::DATA_W-1:0] out_value_reg, out_value_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_empty_reg, out_empty_next;
    logic                        out_ovf_reg, out_ovf_next;

    logic                        a_full;
    logic                        b_full;
    logic                        push;
    logic [ssme_pkg::DATA_W-1:0] emit_value;

    assign a_full = (count_a_reg == ssme_pkg::CNT_W'(ssme_pkg::LIST_DEPTH));
    assign b_full = (count_b_reg == ssme_pkg::CNT_W'(ssme_pkg::LIST_DEPTH));
    assign emit_value = cmd.emit_sel_b ? rd_b_reg : rd_a_reg;
    assign push = (cmd.emit && pend_valid_reg) || cmd.fin;

    // Memories: one write and one registered read per list each cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.load_a && !a_full)
        begin
            mem_a[count_a_reg[ssme_pkg::IDX_W-1:0]] <= element;
        end
        if (cmd.load_b && !b_full)
        begin
            mem_b[count_b_reg[ssme_pkg::IDX_W-1:0]] <= element;
        end
        rd_a_reg <= mem_a[ptr_i_reg[ssme_pkg::IDX_W-1:0]];
        rd_b_reg <= mem_b[ptr_j_reg[ssme_pkg::IDX_W-1:0]];
    end

    always_comb
    begin
        count_a_next    = count_a_reg;
        count_b_next    = count_b_reg;
        dropped_next    = dropped_reg;
        ptr_i_next      = ptr_i_reg;
        ptr_j_next      = ptr_j_reg;
        pend_value_next = pend_value_reg;
        pend_valid_next = pend_valid_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;
        out_ovf_next    = out_ovf_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (cmd.load_a)
        begin
            if (a_full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                count_a_next = count_a_reg + 1'b1;
            end
        end
        if (cmd.load_b)
        begin
            if (b_full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                count_b_next = count_b_reg + 1'b1;
            end
        end

        if (cmd.clr_ptr)
        begin
            ptr_i_next      = '0;
            ptr_j_next      = '0;
            pend_valid_next = 1'b0;
        end
        if (cmd.adv_i)
        begin
            ptr_i_next = ptr_i_reg + 1'b1;
        end
        if (cmd.adv_j)
        begin
            ptr_j_next = ptr_j_reg + 1'b1;
        end

        // The held result goes out only once it is known whether it is the last one.
        if (push)
        begin
            out_valid_next = 1'b1;
            out_value_next = pend_valid_reg ? pend_value_reg : '0;
            out_last_next  = cmd.fin;
            out_empty_next = cmd.fin && !pend_valid_reg;
            out_ovf_next   = dropped_reg;
        end
        if (cmd.emit)
        begin
            pend_value_next = emit_value;
            pend_valid_next = 1'b1;
        end
        if (cmd.fin)
        begin
            pend_valid_next = 1'b0;
            dropped_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg    <= '0;
            count_b_reg    <= '0;
            dropped_reg    <= 1'b0;
            ptr_i_reg      <= '0;
            ptr_j_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_a_reg    <= count_a_next;
            count_b_reg    <= count_b_next;
            dropped_reg    <= dropped_next;
            ptr_i_reg      <= ptr_i_next;
            ptr_j_reg      <= ptr_j_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_value_reg <= pend_value_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
        out_empty_reg  <= out_empty_next;
        out_ovf_reg    <= out_ovf_next;
    end

    always_comb
    begin
        status.a_avail    = (ptr_i_reg < count_a_reg);
        status.b_avail    = (ptr_j_reg < count_b_reg);
        status.a_lt_b     = ($signed(rd_a_reg) < $signed(rd_b_reg));
        status.b_lt_a     = ($signed(rd_b_reg) < $signed(rd_a_reg));
        status.pend_valid = pend_valid_reg;
        status.out_busy   = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;
    assign value     = $signed(out_value_reg);
    assign is_last   = out_last_reg;
    assign is_empty  = out_empty_reg;
    assign overflow  = out_ovf_reg;

    // A walk pointer never runs past the count of its list.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ptr_i_reg <= count_a_reg) && (ptr_j_reg <= count_b_reg))
        else $error("walk pointer beyond list count");

    // A result is never pushed over one that is still waiting to be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !(out_valid_reg && !out_ready))
        else $error("result pushed into a stalled output register");

endmodule

`default_nettype wire

### design/ssme_ctrl.sv
// Controller: state machine that sequences loads and the two-pointer walk.
`default_nettype none

module ssme_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [1:0]           op,
    input  wire logic [1:0]           mode,
    input  wire ssme_pkg::ssme_stat_t status,
    output logic                      in_ready,
    output ssme_pkg::ssme_cmd_t       cmd
);

    ssme_pkg::ssme_state_t state_reg, state_next;

    logic want_a;
    logic want_b;
    logic step_i;
    logic step_j;
    logic done;
    logic stall;

    // Walk decision for the pair of heads read in the previous cycle.
    always_comb
    begin
        want_a = 1'b0;
        want_b = 1'b0;
        step_i = 1'b0;
        step_j = 1'b0;
        done   = 1'b0;
        if (status.a_avail && status.b_avail)
        begin
            if (status.a_lt_b)
            begin
                want_a = (mode != ssme_pkg::MODE_INTER);
                step_i = 1'b1;
            end
            else if (status.b_lt_a)
            begin
                want_b = (mode == ssme_pkg::MODE_MERGE) || (mode == ssme_pkg::MODE_UNION);
                step_j = 1'b1;
            end
            else if (mode == ssme_pkg::MODE_MERGE)
            begin
                want_b = 1'b1;
                step_j = 1'b1;
            end
            else
            begin
                want_a = (mode == ssme_pkg::MODE_UNION) || (mode == ssme_pkg::MODE_INTER);
                step_i = 1'b1;
                step_j = 1'b1;
            end
        end
        else if (status.a_avail && (mode != ssme_pkg::MODE_INTER))
        begin
            want_a = 1'b1;
            step_i = 1'b1;
        end
        else if (status.b_avail &&
                 ((mode == ssme_pkg::MODE_MERGE) || (mode == ssme_pkg::MODE_UNION)))
        begin
            want_b = 1'b1;
            step_j = 1'b1;
        end
        else
        begin
            done = 1'b1;
        end
        stall = (want_a || want_b) && status.pend_valid && status.out_busy;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ssme_pkg::ST_IDLE:
            begin
                if (in_valid && (op == ssme_pkg::OP_RUN))
                begin
                    state_next = ssme_pkg::ST_RD;
                end
            end
            ssme_pkg::ST_RD:
            begin
                state_next = ssme_pkg::ST_CMP;
            end
            ssme_pkg::ST_CMP:
            begin
                if (done)
                begin
                    state_next = ssme_pkg::ST_FIN;
                end
                else if (!stall)
                begin
                    state_next = ssme_pkg::ST_RD;
                end
            end
            ssme_pkg::ST_FIN:
            begin
                if (!status.out_busy)
                begin
                    state_next = ssme_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssme_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ssme_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_a  = in_valid && (op == ssme_pkg::OP_LOAD_A);
                cmd.load_b  = in_valid && (op == ssme_pkg::OP_LOAD_B);
                cmd.clr_ptr = in_valid && (op == ssme_pkg::OP_RUN);
            end
            ssme_pkg::ST_CMP:
            begin
                cmd.adv_i      = step_i && !stall;
                cmd.adv_j      = step_j && !stall;
                cmd.emit       = (want_a || want_b) && !stall;
                cmd.emit_sel_b = want_b;
            end
            ssme_pkg::ST_FIN:
            begin
                cmd.fin = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssme_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // An accepted run always starts with a memory read cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (op == ssme_pkg::OP_RUN)) |=> (state_reg == ssme_pkg::ST_RD))
        else $error("run transfer did not start the walk");

    // Read data is always compared in the cycle after the read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssme_pkg::ST_RD) |=> (state_reg == ssme_pkg::ST_CMP))
        else $error("read cycle not followed by compare");

    // Once the final result is pushed the engine is free for the next transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |=> (state_reg == ssme_pkg::ST_IDLE) && in_ready)
        else $error("engine not idle after final result");

endmodule

`default_nettype wire
